// ===== rtl/core/srs_pkg.sv =====
// srs_pkg: types and codes shared by the range shot sequencer
// no dependencies; included first by every other file of the block
package srs_pkg;

    localparam int unsigned TimeW   = 32;
    localparam int unsigned NearW   = 16;
    localparam int unsigned FarW    = 32;
    localparam int unsigned PosW    = 8;
    localparam int unsigned CfgIdxW = 1;
    localparam int unsigned CfgW    = 32;

    localparam logic [TimeW-1:0] TimeMax         = '1;
    localparam logic [TimeW-1:0] PosTimeoutRst   = TimeW'(1000);
    localparam logic [TimeW-1:0] MeasTimeoutRst  = TimeW'(1000);

    typedef enum logic [CfgIdxW-1:0] {
        CFG_POS_TIMEOUT  = 1'b0,
        CFG_MEAS_TIMEOUT = 1'b1
    } cfg_idx_t;

    typedef enum logic [2:0] {
        KIND_START     = 3'd0,
        KIND_TICK      = 3'd1,
        KIND_STEP      = 3'd2,
        KIND_READ_NEAR = 3'd3,
        KIND_READ_FAR  = 3'd4,
        KIND_READ_POS  = 3'd5,
        KIND_QUERY     = 3'd6
    } kind_t;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_POS  = 2'd1,
        PH_MEAS = 2'd2,
        PH_DONE = 2'd3
    } phase_t;

    typedef struct packed {
        logic [2:0]       kind;
        logic [PosW-1:0]  target_position;
        logic             servo_ready;
        logic             sensors_ready;
        logic             far_valid;
        logic [FarW-1:0]  far_distance;
        logic             near_valid;
        logic [NearW-1:0] near_distance;
    } srs_in_t;

    typedef struct packed {
        logic             accepted;
        logic             finished;
        logic             servo_command;
        logic             trigger_sensors;
        logic [PosW-1:0]  position_out;
        logic [NearW-1:0] near_out;
        logic [FarW-1:0]  far_out;
        logic [1:0]       phase_out;
    } srs_out_t;

    typedef struct packed {
        phase_t           phase;
        logic [TimeW-1:0] elapsed;
        logic             near_latched;
        logic             far_latched;
        logic [NearW-1:0] near_value;
        logic [FarW-1:0]  far_value;
        logic [PosW-1:0]  held_position;
    } srs_state_t;

    typedef struct packed {
        logic [TimeW-1:0] pos_timeout;
        logic [TimeW-1:0] meas_timeout;
    } srs_cfg_t;

endpackage

// ===== rtl/core/srs_in_if.sv =====
// srs_in_if: valid/ready channel carrying one sequencer item
// depends on srs_pkg for the payload type
interface srs_in_if;
    import srs_pkg::*;

    logic    valid;
    logic    ready;
    srs_in_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/core/srs_out_if.sv =====
// srs_out_if: valid/ready channel carrying one sequencer result
// depends on srs_pkg for the payload type
interface srs_out_if;
    import srs_pkg::*;

    logic     valid;
    logic     ready;
    srs_out_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/core/srs_step.sv =====
// srs_step: next state and result of the sequencer for one item
// depends on srs_pkg; purely combinational, registered by the top level
module srs_step (
    input  srs_pkg::srs_state_t cur,
    input  srs_pkg::srs_cfg_t   cfg,
    input  srs_pkg::srs_in_t    item,
    output srs_pkg::srs_state_t nxt,
    output srs_pkg::srs_out_t   res
);
    import srs_pkg::*;

    logic at_rest;
    logic start_ok;
    logic pos_ready;

    assign at_rest   = (cur.phase == PH_IDLE) || (cur.phase == PH_DONE);
    assign start_ok  = at_rest && item.servo_ready;
    assign pos_ready = item.servo_ready && item.sensors_ready;

    // next state
    always_comb
    begin
        nxt = cur;
        unique case (item.kind)
            KIND_START:
            begin
                if (start_ok)
                begin
                    nxt.near_latched  = 1'b0;
                    nxt.far_latched   = 1'b0;
                    nxt.elapsed       = '0;
                    nxt.held_position = item.target_position;
                    nxt.phase         = PH_POS;
                end
            end
            KIND_TICK:
            begin
                if (cur.elapsed != TimeMax)
                begin
                    nxt.elapsed = cur.elapsed + TimeW'(1);
                end
            end
            KIND_STEP:
            begin
                unique case (cur.phase)
                    PH_POS:
                    begin
                        if (cur.elapsed > cfg.pos_timeout)
                        begin
                            nxt.phase   = PH_IDLE;
                            nxt.elapsed = '0;
                        end
                        if (pos_ready)
                        begin
                            nxt.phase   = PH_MEAS;
                            nxt.elapsed = '0;
                        end
                    end
                    PH_MEAS:
                    begin
                        // timeout forces zero into missing latches before capture
                        if (cur.elapsed > cfg.meas_timeout)
                        begin
                            nxt.elapsed = '0;
                            if (!cur.far_latched)
                            begin
                                nxt.far_value   = '0;
                                nxt.far_latched = 1'b1;
                            end
                            if (!cur.near_latched)
                            begin
                                nxt.near_value   = '0;
                                nxt.near_latched = 1'b1;
                            end
                        end
                        if (!nxt.far_latched && item.far_valid)
                        begin
                            nxt.far_value   = item.far_distance;
                            nxt.far_latched = 1'b1;
                        end
                        if (!nxt.near_latched && item.near_valid)
                        begin
                            nxt.near_value   = item.near_distance;
                            nxt.near_latched = 1'b1;
                        end
                        if (nxt.far_latched && nxt.near_latched)
                        begin
                            nxt.phase = PH_DONE;
                        end
                    end
                    PH_DONE:
                    begin
                        if (!cur.far_latched && !cur.near_latched)
                        begin
                            nxt.phase = PH_IDLE;
                        end
                    end
                    PH_IDLE:
                    begin
                    end
                    default:
                    begin
                    end
                endcase
            end
            KIND_READ_NEAR:
            begin
                if (at_rest)
                begin
                    nxt.near_latched = 1'b0;
                end
            end
            KIND_READ_FAR:
            begin
                if (at_rest)
                begin
                    nxt.far_latched = 1'b0;
                end
            end
            default:
            begin
            end
        endcase
    end

    // result fields
    always_comb
    begin
        res = '0;
        unique case (item.kind)
            KIND_START:
            begin
                res.accepted      = start_ok;
                res.servo_command = start_ok;
            end
            KIND_STEP:
            begin
                res.trigger_sensors = (cur.phase == PH_POS) && pos_ready;
            end
            KIND_READ_NEAR, KIND_READ_FAR:
            begin
                res.accepted = at_rest;
            end
            KIND_READ_POS:
            begin
                res.accepted = 1'b1;
            end
            default:
            begin
            end
        endcase
        res.finished     = (nxt.phase == PH_IDLE) || (nxt.phase == PH_DONE);
        res.position_out = nxt.held_position;
        res.near_out     = nxt.near_value;
        res.far_out      = nxt.far_value;
        res.phase_out    = nxt.phase;
    end
endmodule

// ===== rtl/core/scan_ranging_sequencer.sv =====
// scan_ranging_sequencer: top level of the servo-aimed dual-sensor range shot sequencer
// depends on srs_pkg, srs_in_if, srs_out_if and srs_step
//
// usage:
//   in_ch carries one item per transfer (start, tick, step, reads, query);
//   out_ch returns exactly one result per item, in order.
//   cfg_we/cfg_index/cfg_wdata write position_timeout (0) and
//   measure_timeout (1); write only while no item is in flight.
// path: an accepted item waits in the input register; its result is then
//   captured in the result register and offered on out_ch until taken.
// throughput: one item per cycle while out_ch is ready; the state update is a single
//   pass of srs_step between the input register and the result register.
// stall: while out_ch is not ready the result holds, the input register
//   still takes one more item, then in_ch.ready drops until space frees.
// reset: phase idle, timer, latches, values and position cleared,
//   both timeouts set to 1000, both channel stages empty.
module scan_ranging_sequencer (
    input  logic                           clk,
    input  logic                           rst_n,
    srs_in_if.sink                         in_ch,
    srs_out_if.source                      out_ch,
    input  logic                           cfg_we,
    input  logic [srs_pkg::CfgIdxW-1:0]    cfg_index,
    input  logic [srs_pkg::CfgW-1:0]       cfg_wdata
);
    import srs_pkg::*;

    srs_state_t state_reg;
    srs_state_t state_next;
    srs_cfg_t   cfg_reg;
    srs_in_t    in_reg;
    logic       in_valid_reg;
    srs_out_t   out_reg;
    srs_out_t   out_next;
    logic       out_valid_reg;
    logic       advance;

    // stage moves into the result register when that register is free
    assign advance      = in_valid_reg && (!out_valid_reg || out_ch.ready);
    assign in_ch.ready  = !in_valid_reg || advance;
    assign out_ch.valid = out_valid_reg;
    assign out_ch.data  = out_reg;

    srs_step u_step (
        .cur  (state_reg),
        .cfg  (cfg_reg),
        .item (in_reg),
        .nxt  (state_next),
        .res  (out_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pos_timeout  <= PosTimeoutRst;
            cfg_reg.meas_timeout <= MeasTimeoutRst;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_POS_TIMEOUT:  cfg_reg.pos_timeout  <= cfg_wdata;
                CFG_MEAS_TIMEOUT: cfg_reg.meas_timeout <= cfg_wdata;
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.phase         <= PH_IDLE;
            state_reg.elapsed       <= '0;
            state_reg.near_latched  <= 1'b0;
            state_reg.far_latched   <= 1'b0;
            state_reg.near_value    <= '0;
            state_reg.far_value     <= '0;
            state_reg.held_position <= '0;
            in_valid_reg            <= 1'b0;
            out_valid_reg           <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                state_reg <= state_next;
            end
            if (in_ch.ready)
            begin
                in_valid_reg <= in_ch.valid;
            end
            if (!out_valid_reg || out_ch.ready)
            begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ch.valid && in_ch.ready)
        begin
            in_reg <= in_ch.data;
        end
        if (advance)
        begin
            out_reg <= out_next;
        end
    end
endmodule
